[rtl/core/cgacd_pkg.sv]
// ----------------------------------------------------------------------------
// cgacd_pkg
// Shared types and constants of the composite color decoder: sample and
// window types, register map, configuration bundle and decoded pixel record.
// ----------------------------------------------------------------------------
`default_nettype none

package cgacd_pkg;

  localparam int SAMPLE_W    = 14;
  localparam int TABLE_DEPTH = 1024;
  localparam int TABLE_AW    = 10;
  localparam int WINDOW_LEN  = 11;
  localparam int POS_W       = 11;
  localparam int LINE_W      = 12;
  localparam int GAIN_W      = 16;
  localparam int NUM_GAINS   = 6;
  localparam int SHARP_W     = 8;
  localparam int LEVEL_W     = 4;
  localparam int OUT_SHIFT   = 13 + 4;
  localparam int FIRST_EMIT  = 10;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 4'd15;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [WINDOW_LEN-1:0][SAMPLE_W-1:0] window_t;

  typedef enum logic [2:0] {
    REG_RED_I   = 3'd0,
    REG_RED_Q   = 3'd1,
    REG_GREEN_I = 3'd2,
    REG_GREEN_Q = 3'd3,
    REG_BLUE_I  = 3'd4,
    REG_BLUE_Q  = 3'd5,
    REG_SHARPEN = 3'd6,
    REG_OUT_EN  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [NUM_GAINS-1:0][GAIN_W-1:0] gain;
    logic [SHARP_W-1:0]               sharpen;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0]   pos;
    logic [LEVEL_W-1:0] blue;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] red;
  } pix_t;

endpackage

`default_nettype wire

[rtl/core/cgacd_level_table.sv]
// ----------------------------------------------------------------------------
// cgacd_level_table
// Composite level memory: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cgacd_level_table (
  input  wire                               clk,
  input  wire                               wr_en,
  input  wire  [cgacd_pkg::TABLE_AW-1:0]    wr_addr,
  input  wire  cgacd_pkg::sample_t          wr_data,
  input  wire                               rd_en,
  input  wire  [cgacd_pkg::TABLE_AW-1:0]    rd_addr,
  output cgacd_pkg::sample_t                rd_data
);

  cgacd_pkg::sample_t mem [cgacd_pkg::TABLE_DEPTH];
  cgacd_pkg::sample_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[rtl/core/cgacd_tap_cell.sv]
// ----------------------------------------------------------------------------
// cgacd_tap_cell
// One tap of the sample window: holds a composite level and takes its
// neighbor's level on each shift.
// ----------------------------------------------------------------------------
`default_nettype none

module cgacd_tap_cell (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      shift_en,
  input  wire  cgacd_pkg::sample_t din,
  output cgacd_pkg::sample_t       q
);

  cgacd_pkg::sample_t q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (shift_en) begin
      q_r <= din;
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

[rtl/core/cgacd_decode.sv]
// ----------------------------------------------------------------------------
// cgacd_decode
// Chroma/luma filters over the window, sharpening, phase rotation, color
// matrix and clamp, in three register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module cgacd_decode (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              adv,
  input  wire                              in_valid,
  input  wire  [cgacd_pkg::POS_W-1:0]      in_pos,
  input  wire  cgacd_pkg::window_t         win,
  input  wire  cgacd_pkg::cfg_t            cfg,
  output logic                             res_valid,
  output cgacd_pkg::pix_t                  res
);

  localparam int CH_W  = 18;
  localparam int L_W   = 19;
  localparam int SUM_W = 21;
  localparam int Y_W   = 30;
  localparam int P_W   = 34;
  localparam int ACC_W = 36;

  function automatic logic signed [CH_W-1:0] chroma(
    input logic signed [cgacd_pkg::SAMPLE_W-1:0] w0,
    input logic signed [cgacd_pkg::SAMPLE_W-1:0] w2,
    input logic signed [cgacd_pkg::SAMPLE_W-1:0] w4,
    input logic signed [cgacd_pkg::SAMPLE_W-1:0] w6,
    input logic signed [cgacd_pkg::SAMPLE_W-1:0] w8
  );
    logic signed [CH_W-1:0] mid;
    mid = CH_W'(w2) - CH_W'(w4) + CH_W'(w6);
    return CH_W'(w0) - (mid <<< 1) + CH_W'(w8);
  endfunction

  function automatic logic [cgacd_pkg::LEVEL_W-1:0] clamp(
    input logic signed [ACC_W-1:0] v
  );
    logic [cgacd_pkg::LEVEL_W-1:0] lvl;
    if (v[ACC_W-1]) begin
      lvl = '0;
    end else if (|v[ACC_W-2:cgacd_pkg::OUT_SHIFT+cgacd_pkg::LEVEL_W]) begin
      lvl = cgacd_pkg::LEVEL_MAX;
    end else begin
      lvl = v[cgacd_pkg::OUT_SHIFT+cgacd_pkg::LEVEL_W-1:cgacd_pkg::OUT_SHIFT];
    end
    return lvl;
  endfunction

  // window taps as signed samples
  logic signed [cgacd_pkg::SAMPLE_W-1:0] w [cgacd_pkg::WINDOW_LEN];

  always_comb begin
    for (int j = 0; j < cgacd_pkg::WINDOW_LEN; j++) begin
      w[j] = $signed(win[j]);
    end
  end

  // stage 2: filters
  logic signed [CH_W-1:0]  a_prev, a_cur, a_next, b_c;
  logic signed [L_W-1:0]   l_prev, l_cur, l_next;
  logic signed [SUM_W-1:0] c_v, d_v;

  always_comb begin
    a_prev = chroma(w[0], w[2], w[4], w[6], w[8]);
    a_cur  = chroma(w[1], w[3], w[5], w[7], w[9]);
    a_next = chroma(w[2], w[4], w[6], w[8], w[10]);
    b_c    = (CH_W'(w[2]) - CH_W'(w[4]) + CH_W'(w[6]) - CH_W'(w[8])) <<< 1;
    l_prev = (L_W'(w[4]) <<< 3) - L_W'(a_prev);
    l_cur  = (L_W'(w[5]) <<< 3) - L_W'(a_cur);
    l_next = (L_W'(w[6]) <<< 3) - L_W'(a_next);
    c_v    = SUM_W'(l_cur) <<< 1;
    d_v    = SUM_W'(l_prev) + SUM_W'(l_next);
  end

  logic                           v2_r;
  logic [cgacd_pkg::POS_W-1:0]    pos2_r;
  logic signed [CH_W-1:0]         a2_r, b2_r;
  logic signed [SUM_W-1:0]        sum2_r, diff2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos2_r  <= in_pos;
      a2_r    <= a_cur;
      b2_r    <= b_c;
      sum2_r  <= c_v + d_v;
      diff2_r <= c_v - d_v;
    end
  end

  // stage 3: sharpened luma and chroma rotated by pixel phase
  logic signed [cgacd_pkg::SHARP_W:0] g_s;
  logic signed [Y_W-1:0]              sharp_p, y_c;
  logic signed [CH_W-1:0]             ci_c, cq_c;

  always_comb begin
    g_s     = $signed({1'b0, cfg.sharpen});
    sharp_p = Y_W'(g_s) * Y_W'(diff2_r);
    y_c     = (Y_W'(sum2_r) <<< 8) + sharp_p;
    unique case (pos2_r[1:0])
      2'd0: begin
        ci_c = a2_r;
        cq_c = b2_r;
      end
      2'd1: begin
        ci_c = -b2_r;
        cq_c = a2_r;
      end
      2'd2: begin
        ci_c = -a2_r;
        cq_c = -b2_r;
      end
      default: begin
        ci_c = b2_r;
        cq_c = -a2_r;
      end
    endcase
  end

  logic                        v3_r;
  logic [cgacd_pkg::POS_W-1:0] pos3_r;
  logic signed [Y_W-1:0]       y3_r;
  logic signed [CH_W-1:0]      ci3_r, cq3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos3_r <= pos2_r;
      y3_r   <= y_c;
      ci3_r  <= ci_c;
      cq3_r  <= cq_c;
    end
  end

  // stage 4: color gains, even entries on i, odd on q
  logic signed [P_W-1:0] prod_c [cgacd_pkg::NUM_GAINS];

  always_comb begin
    for (int g = 0; g < cgacd_pkg::NUM_GAINS; g += 2) begin
      prod_c[g]   = P_W'($signed(cfg.gain[g])) * P_W'(ci3_r);
      prod_c[g+1] = P_W'($signed(cfg.gain[g+1])) * P_W'(cq3_r);
    end
  end

  logic                        v4_r;
  logic [cgacd_pkg::POS_W-1:0] pos4_r;
  logic signed [Y_W-1:0]       y4_r;
  logic signed [P_W-1:0]       prod4_r [cgacd_pkg::NUM_GAINS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos4_r <= pos3_r;
      y4_r   <= y3_r;
      for (int g = 0; g < cgacd_pkg::NUM_GAINS; g++) begin
        prod4_r[g] <= prod_c[g];
      end
    end
  end

  // channel sums and clamp feed the output register
  logic signed [ACC_W-1:0] acc_r_c, acc_g_c, acc_b_c;

  always_comb begin
    acc_r_c = ACC_W'(y4_r) + ACC_W'(prod4_r[0]) + ACC_W'(prod4_r[1]);
    acc_g_c = ACC_W'(y4_r) + ACC_W'(prod4_r[2]) + ACC_W'(prod4_r[3]);
    acc_b_c = ACC_W'(y4_r) + ACC_W'(prod4_r[4]) + ACC_W'(prod4_r[5]);
    res.red   = clamp(acc_r_c);
    res.green = clamp(acc_g_c);
    res.blue  = clamp(acc_b_c);
    res.pos   = pos4_r;
  end

  assign res_valid = v4_r;

endmodule

`default_nettype wire

[rtl/core/cga_composite_color_decoder.sv]
// Order: pixel n is emitted after the edge that accepts pixel n+10 of the same
// line (table read, window shift, filter, rotate, gain stages).
// Throughput: one beat per cycle, pixel or table write, while the skid entry is
// empty; an output register plus one skid entry keep input flowing while a result waits.
// Reset: counters, window and valid flags clear, gains 0, output enabled; the
// level table holds no defined contents until written.
// ----------------------------------------------------------------------------
// cga_composite_color_decoder
// Composite artifact color decoder: RGBI pixels in, clamped 4-bit RGB out.
// ----------------------------------------------------------------------------
`default_nettype none

module cga_composite_color_decoder #(
  parameter int MAX_LINE_WIDTH = 2048
) (
  input  wire         clk,
  input  wire         rst_n,
  // in_tdata: pixel[3:0], table_address[13:4], table_value[27:14], zero[31:28]
  input  wire  [31:0] in_tdata,
  // in_tuser: mode
  input  wire         in_tuser,
  // in_tlast: line_last
  input  wire         in_tlast,
  input  wire         in_tvalid,
  output logic        in_tready,
  // out_tdata: red[3:0], green[7:4], blue[11:8], position[22:12], zero[23]
  output logic [23:0] out_tdata,
  output logic        out_tvalid,
  input  wire         out_tready,
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [4:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CNT_W = $clog2(MAX_LINE_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_LINE_WIDTH - 1);

  // configuration registers
  logic [cgacd_pkg::NUM_GAINS-1:0][cgacd_pkg::GAIN_W-1:0] gain_r;
  logic [cgacd_pkg::SHARP_W-1:0]                          sharpen_r;
  logic                                                   out_en_r;
  cgacd_pkg::reg_idx_t                                    reg_idx;
  logic                                                   cfg_wr;
  cgacd_pkg::cfg_t                                        cfg;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cgacd_pkg::reg_idx_t'(cfg_paddr[4:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r    <= '0;
      sharpen_r <= '0;
      out_en_r  <= 1'b1;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        cgacd_pkg::REG_RED_I:   gain_r[0] <= cfg_pwdata[cgacd_pkg::GAIN_W-1:0];
        cgacd_pkg::REG_RED_Q:   gain_r[1] <= cfg_pwdata[cgacd_pkg::GAIN_W-1:0];
        cgacd_pkg::REG_GREEN_I: gain_r[2] <= cfg_pwdata[cgacd_pkg::GAIN_W-1:0];
        cgacd_pkg::REG_GREEN_Q: gain_r[3] <= cfg_pwdata[cgacd_pkg::GAIN_W-1:0];
        cgacd_pkg::REG_BLUE_I:  gain_r[4] <= cfg_pwdata[cgacd_pkg::GAIN_W-1:0];
        cgacd_pkg::REG_BLUE_Q:  gain_r[5] <= cfg_pwdata[cgacd_pkg::GAIN_W-1:0];
        cgacd_pkg::REG_SHARPEN: sharpen_r <= cfg_pwdata[cgacd_pkg::SHARP_W-1:0];
        default:                out_en_r  <= cfg_pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      cgacd_pkg::REG_RED_I:   cfg_prdata = 32'(gain_r[0]);
      cgacd_pkg::REG_RED_Q:   cfg_prdata = 32'(gain_r[1]);
      cgacd_pkg::REG_GREEN_I: cfg_prdata = 32'(gain_r[2]);
      cgacd_pkg::REG_GREEN_Q: cfg_prdata = 32'(gain_r[3]);
      cgacd_pkg::REG_BLUE_I:  cfg_prdata = 32'(gain_r[4]);
      cgacd_pkg::REG_BLUE_Q:  cfg_prdata = 32'(gain_r[5]);
      cgacd_pkg::REG_SHARPEN: cfg_prdata = 32'(sharpen_r);
      default:                cfg_prdata = 32'(out_en_r);
    endcase
  end

  assign cfg = {gain_r, sharpen_r};

  // pipeline advance: held only while the skid entry is occupied
  logic skid_valid_r;
  logic adv;
  logic in_beat;
  logic pix_beat;
  logic tab_beat;

  assign adv       = !skid_valid_r;
  assign in_tready = adv;
  assign in_beat   = in_tvalid && in_tready;
  assign pix_beat  = in_beat && !in_tuser;
  assign tab_beat  = in_beat && in_tuser;

  logic [3:0]                     in_pixel;
  logic [cgacd_pkg::TABLE_AW-1:0] in_tab_addr;
  cgacd_pkg::sample_t             in_tab_val;

  assign in_pixel    = in_tdata[3:0];
  assign in_tab_addr = in_tdata[13:4];
  assign in_tab_val  = in_tdata[27:14];

  // line position and previous pixel
  logic [CNT_W-1:0]             line_cnt_r, line_cnt_nxt;
  logic [3:0]                   prev_pix_r, prev_pix_nxt;
  logic [cgacd_pkg::LINE_W-1:0] cnt_ext;
  logic [cgacd_pkg::TABLE_AW-1:0] rd_addr;

  always_comb begin
    cnt_ext = cgacd_pkg::LINE_W'(line_cnt_r);
    // phase of pixel p is (p - 1) mod 4
    rd_addr = {prev_pix_r, in_pixel, line_cnt_r[1:0] + 2'd3};
    if (in_tlast || line_cnt_r == CNT_LAST) begin
      line_cnt_nxt = '0;
      prev_pix_nxt = '0;
    end else begin
      line_cnt_nxt = line_cnt_r + CNT_W'(1);
      prev_pix_nxt = in_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_cnt_r <= '0;
      prev_pix_r <= '0;
    end else if (pix_beat) begin
      line_cnt_r <= line_cnt_nxt;
      prev_pix_r <= prev_pix_nxt;
    end
  end

  cgacd_pkg::sample_t rd_data;

  cgacd_level_table u_table (
    .clk     (clk),
    .wr_en   (tab_beat),
    .wr_addr (in_tab_addr),
    .wr_data (in_tab_val),
    .rd_en   (pix_beat),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // stage 0: table read in flight
  logic                        v0_r;
  logic                        emit0_r;
  logic [cgacd_pkg::POS_W-1:0] pos0_r;
  logic [cgacd_pkg::LINE_W-1:0] pos_full;

  assign pos_full = cnt_ext - cgacd_pkg::LINE_W'(cgacd_pkg::FIRST_EMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= pix_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      emit0_r <= cnt_ext >= cgacd_pkg::LINE_W'(cgacd_pkg::FIRST_EMIT);
      pos0_r  <= pos_full[cgacd_pkg::POS_W-1:0];
    end
  end

  // stage 1: window of tap cells, newest level enters at the top
  logic                        win_shift;
  logic                        v1_r;
  logic [cgacd_pkg::POS_W-1:0] pos1_r;
  cgacd_pkg::sample_t          tap_q [cgacd_pkg::WINDOW_LEN];
  cgacd_pkg::window_t          win;

  assign win_shift = adv && v0_r;

  for (genvar j = 0; j < cgacd_pkg::WINDOW_LEN; j++) begin : g_tap
    if (j == cgacd_pkg::WINDOW_LEN - 1) begin : g_top
      cgacd_tap_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (win_shift),
        .din      (rd_data),
        .q        (tap_q[j])
      );
    end else begin : g_mid
      cgacd_tap_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (win_shift),
        .din      (tap_q[j+1]),
        .q        (tap_q[j])
      );
    end
  end

  always_comb begin
    for (int j = 0; j < cgacd_pkg::WINDOW_LEN; j++) begin
      win[j] = tap_q[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v0_r && emit0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pos1_r <= pos0_r;
    end
  end

  logic            res_valid;
  cgacd_pkg::pix_t res;

  cgacd_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (v1_r),
    .in_pos    (pos1_r),
    .win       (win),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // output register and skid entry
  logic            push;
  logic            out_free;
  logic            out_valid_r;
  cgacd_pkg::pix_t out_pix_r;
  cgacd_pkg::pix_t skid_pix_r;

  assign push     = adv && res_valid && out_en_r;
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= push || skid_valid_r;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_pix_r <= skid_valid_r ? skid_pix_r : res;
    end else if (push) begin
      skid_pix_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_pix_r.pos, out_pix_r.blue, out_pix_r.green,
                       out_pix_r.red};

endmodule

`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the composite color decoder. Loads the level table,
// streams scan lines of RGBI pixels under several gain settings, models the
// window, chroma filters, rotation and clamping, and checks every decoded beat.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_LIMIT   = 2048;
  localparam int IDLE_PCT     = 29;
  localparam int STEADY_FROM  = 1700;
  localparam int STEADY_TO    = 2200;
  localparam int SQUEEZE_AT   = 12;
  localparam int HOLD_CYCLES  = 150;
  localparam int DRAIN_CYCLES = 20;
  localparam int QUIET_LIMIT  = 4000;
  localparam int REPORT_CAP   = 40;
  localparam int PHASE_BEATS  = 48;

  typedef enum bit {KIND_PIXEL = 1'b0, KIND_TABLE = 1'b1} beat_kind_t;

  typedef struct {
    beat_kind_t         mode;
    logic [3:0]         pixel;
    logic               last;
    logic [9:0]         addr;
    logic signed [13:0] value;
  } in_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] out_tdata;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  cga_composite_color_decoder #(.MAX_LINE_WIDTH(LINE_LIMIT)) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // decoder state as the block should hold it
  int          level_mem [cgacd_pkg::TABLE_DEPTH];
  longint      win_mem [cgacd_pkg::WINDOW_LEN];
  logic [3:0]  prev_pixel_q = '0;
  int          line_pos = 0;
  longint      chan_gain [cgacd_pkg::NUM_GAINS];
  longint      sharp_wt = 0;
  bit          decode_on = 1'b1;
  logic [31:0] reg_shadow [8];

  in_beat_t        beat_q[$];
  cgacd_pkg::pix_t decoded_q[$];

  int mismatch_cnt = 0;
  int results_seen = 0;
  int cyc_cnt = 0;

  initial begin
    foreach (win_mem[i]) win_mem[i] = 0;
    foreach (chan_gain[i]) chan_gain[i] = 0;
  end

  task automatic report_mismatch(string what, int at, longint got, longint want);
    if (mismatch_cnt < REPORT_CAP)
      $display("%0t mismatch %s at pixel %0d: got %0d want %0d", $realtime, what, at, got,
               want);
    mismatch_cnt++;
  endtask

  function automatic bit take_idle();
    if (cyc_cnt >= STEADY_FROM && cyc_cnt < STEADY_TO) return 1'b0;
    return $urandom_range(99) < IDLE_PCT;
  endfunction

  function automatic longint chroma_i(int o);
    return win_mem[o] - 2 * (win_mem[o+2] - win_mem[o+4] + win_mem[o+6]) + win_mem[o+8];
  endfunction

  function automatic logic [3:0] clamp_chan(longint s);
    if (s < 0) return 4'd0;
    s = s >>> cgacd_pkg::OUT_SHIFT;
    return (s > cgacd_pkg::LEVEL_MAX) ? cgacd_pkg::LEVEL_MAX : 4'(s);
  endfunction

  // advance the decoder by one accepted beat and queue the pixel it releases
  task automatic decode_beat(in_beat_t b);
    logic [9:0] idx;
    longint a_prev, a_mid, a_next, qd, l_prev, l_mid, l_next, c, d, y, ci, cq;
    int k;
    cgacd_pkg::pix_t px;
    if (b.mode == KIND_TABLE) begin
      level_mem[b.addr] = b.value;
    end else begin
      idx = {prev_pixel_q, b.pixel, 2'(line_pos + 3)};
      for (int j = 0; j < cgacd_pkg::WINDOW_LEN - 1; j++) win_mem[j] = win_mem[j+1];
      win_mem[cgacd_pkg::WINDOW_LEN-1] = level_mem[idx];
      if (line_pos >= cgacd_pkg::FIRST_EMIT) begin
        k = line_pos - cgacd_pkg::FIRST_EMIT;
        a_prev = chroma_i(0);
        a_mid  = chroma_i(1);
        a_next = chroma_i(2);
        qd     = 2 * (win_mem[2] - win_mem[4] + win_mem[6] - win_mem[8]);
        l_prev = 8 * win_mem[4] - a_prev;
        l_mid  = 8 * win_mem[5] - a_mid;
        l_next = 8 * win_mem[6] - a_next;
        c = 2 * l_mid;
        d = l_prev + l_next;
        y = (c + d) * 256 + sharp_wt * (c - d);
        // rotate the chroma pair by pixel phase
        case (2'(k))
          2'd0: begin ci = a_mid; cq = qd; end
          2'd1: begin ci = -qd; cq = a_mid; end
          2'd2: begin ci = -a_mid; cq = -qd; end
          default: begin ci = qd; cq = -a_mid; end
        endcase
        if (decode_on) begin
          px.red   = clamp_chan(y + chan_gain[0] * ci + chan_gain[1] * cq);
          px.green = clamp_chan(y + chan_gain[2] * ci + chan_gain[3] * cq);
          px.blue  = clamp_chan(y + chan_gain[4] * ci + chan_gain[5] * cq);
          px.pos   = 11'(k);
          decoded_q.push_back(px);
        end
      end
      if (b.last || line_pos >= LINE_LIMIT - 1) begin
        line_pos = 0;
        prev_pixel_q = '0;
      end else begin
        line_pos++;
        prev_pixel_q = b.pixel;
      end
    end
  endtask

  always @(posedge clk) begin : beat_driver
    logic fire;
    logic offer;
    in_beat_t b;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      fire = in_tvalid && in_tready;
      if (fire) begin
        b = beat_q.pop_front();
        decode_beat(b);
      end
      if (in_tvalid && !fire) offer = 1'b1;
      else offer = (beat_q.size() != 0) && !take_idle();
      in_tvalid <= offer;
      if (offer) begin
        b = beat_q[0];
        in_tuser <= b.mode;
        in_tlast <= b.last;
        in_tdata <= {4'b0, b.value, b.addr, b.pixel};
      end
    end
  end

  always @(posedge clk) begin : pixel_monitor
    cgacd_pkg::pix_t got;
    cgacd_pkg::pix_t want;
    int hold_left;
    bit squeezed;
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left = 0;
      squeezed = 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[22:0];
        results_seen++;
        if (decoded_q.size() == 0) begin
          report_mismatch("unexpected beat", got.pos, got, 0);
        end else begin
          want = decoded_q.pop_front();
          if (got.pos !== want.pos) report_mismatch("position", want.pos, got.pos, want.pos);
          if (got.red !== want.red) report_mismatch("red", want.pos, got.red, want.red);
          if (got.green !== want.green)
            report_mismatch("green", want.pos, got.green, want.green);
          if (got.blue !== want.blue) report_mismatch("blue", want.pos, got.blue, want.blue);
        end
      end
      // one long back-pressure stretch so the input side has to stall
      if (!squeezed && results_seen >= SQUEEZE_AT) begin
        squeezed = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !take_idle();
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int quiet;
    cyc_cnt <= cyc_cnt + 1;
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic push_pixel(logic [3:0] px, logic last);
    in_beat_t b;
    b.mode  = KIND_PIXEL;
    b.pixel = px;
    b.last  = last;
    b.addr  = 10'($urandom);
    b.value = 14'($urandom);
    beat_q.push_back(b);
  endtask

  task automatic push_table(logic [9:0] addr, logic signed [13:0] value);
    in_beat_t b;
    b.mode  = KIND_TABLE;
    b.pixel = 4'($urandom);
    b.last  = 1'($urandom);
    b.addr  = addr;
    b.value = value;
    beat_q.push_back(b);
  endtask

  // small levels keep the decoded channels away from the clamps
  function automatic logic signed [13:0] rand_level(bit wide);
    if (wide) return 14'($urandom);
    return 14'(int'($urandom_range(511)) - 256);
  endfunction

  task automatic push_line(int len);
    for (int i = 0; i < len; i++) begin
      push_pixel(4'($urandom_range(15)), i == len - 1);
      if ($urandom_range(29) == 0)
        push_table(10'($urandom), rand_level($urandom_range(3) == 0));
    end
  endtask

  task automatic drain();
    while (beat_q.size() != 0 || in_tvalid || decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(cgacd_pkg::reg_idx_t r, logic [31:0] v);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {r, 2'b00};
    cfg_pwdata  <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    reg_shadow[r] = v;
    case (r)
      cgacd_pkg::REG_SHARPEN: sharp_wt = longint'(v[7:0]);
      cgacd_pkg::REG_OUT_EN:  decode_on = v[0];
      default:                chan_gain[r] = longint'($signed(v[15:0]));
    endcase
  endtask

  task automatic cfg_check(cgacd_pkg::reg_idx_t r);
    logic [31:0] mask;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {r, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (r)
      cgacd_pkg::REG_SHARPEN: mask = 32'hff;
      cgacd_pkg::REG_OUT_EN:  mask = 32'h1;
      default:                mask = 32'hffff;
    endcase
    if (((cfg_prdata ^ reg_shadow[r]) & mask) != 0)
      report_mismatch("register read", int'(r), cfg_prdata & mask, reg_shadow[r] & mask);
  endtask

  task automatic program_cfg(cgacd_pkg::cfg_t c, bit en);
    for (int i = 0; i < cgacd_pkg::NUM_GAINS; i++)
      cfg_write(cgacd_pkg::reg_idx_t'(i), {{16{c.gain[i][15]}}, c.gain[i]});
    cfg_write(cgacd_pkg::REG_SHARPEN, {24'b0, c.sharpen});
    cfg_write(cgacd_pkg::REG_OUT_EN, {31'b0, en});
    for (int i = 0; i < 8; i++) cfg_check(cgacd_pkg::reg_idx_t'(i));
  endtask

  initial begin : stimulus
    cgacd_pkg::cfg_t c;
    bit en;
    int goal;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every level entry gets a value before any pixel can look it up
    for (int a = 0; a < cgacd_pkg::TABLE_DEPTH; a++)
      push_table(10'(a), rand_level($urandom_range(9) == 0));

    // directed: field extremes, ignored fields, short lines, write inside a line
    push_table(10'd1023, 14'h1fff);
    push_table(10'd0, 14'h2000);
    push_pixel(4'd0, 1'b1);
    for (int i = 0; i < 12; i++) push_pixel(i[0] ? 4'd0 : 4'd15, i == 11);
    for (int i = 0; i < 11; i++) begin
      push_pixel(4'($urandom_range(15)), i == 10);
      if (i == 5) push_table(10'($urandom), rand_level(1'b1));
    end
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      en = 1'b1;
      c.sharpen = 8'($urandom_range(255));
      for (int i = 0; i < cgacd_pkg::NUM_GAINS; i++) begin
        case (ph)
          1: c.gain[i] = 16'h7fff;
          2: c.gain[i] = 16'h8000;
          3, 4: c.gain[i] = 16'($urandom);
          default: c.gain[i] = 16'(int'($urandom_range(600)) - 300);
        endcase
      end
      if (ph == 1) c.sharpen = 8'hff;
      if (ph == 2) c.sharpen = 8'h00;
      if (ph == 3) en = 1'b0;
      program_cfg(c, en);
      goal = beat_q.size() + PHASE_BEATS;
      while (beat_q.size() < goal) begin
        if ($urandom_range(9) < 2) push_line($urandom_range(1, cgacd_pkg::FIRST_EMIT));
        else push_line($urandom_range(cgacd_pkg::FIRST_EMIT + 1, 60));
      end
      drain();
    end

    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
